// ===== hw/rtl/ordered_timer_queue_top_macros.svh =====
// Assertion macros shared by the timer queue RTL.
`ifndef ORDERED_TIMER_QUEUE_TOP_MACROS_SVH
`define ORDERED_TIMER_QUEUE_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define OTQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define OTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/otq_pkg.sv =====
// Types and codes shared by the timer queue modules.
package otq_pkg;
	localparam int ID_W = 48;
	localparam int WAIT_W = 7;
	localparam logic [WAIT_W-1:0] WAIT_CAP = 7'd100;

	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
	} entry_t;

	typedef enum logic [1:0] {
		KIND_CREATE = 2'd0,
		KIND_CANCEL = 2'd1,
		KIND_CHECK  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CREATED   = 3'd0,
		ST_CANCELLED = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EXPIRED   = 3'd3,
		ST_CHECK_DONE = 3'd4,
		ST_FULL      = 3'd5
	} status_t;
endpackage

// ===== hw/rtl/otq_cell.sv =====
// One table slot of the rotating entry ring.
module otq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  otq_pkg::entry_t d,
	output otq_pkg::entry_t q
);
	import otq_pkg::*;

	logic            valid_q;
	logic [ID_W-1:0] id_q;

	// Take the neighbor's entry on each shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			id_q <= d.id;
		end
	end

	assign q.valid = valid_q;
	assign q.id    = id_q;
endmodule

// ===== hw/rtl/ordered_timer_queue_top.sv =====
// Top level of the ordered timer queue: cell ring, scan tap and sequencer.
//
// Timer IDs live in a ring of CAPACITY cells that rotates one position per
// cycle during a scan; a full scan leaves every entry where it started. At
// the ring tap the sequencer removes a cancelled or expired ID, inserts a
// new one, and gathers the smallest ID per clock base and the match and
// free flags. A cancel costs one scan, a create one scan per sequence
// candidate plus one insert scan, a check one scan plus one scan per expired
// timer; each result then has its wait figure registered and waits until
// the downstream takes it. One request is in work at a time.
module ordered_timer_queue_top #(
	parameter int CAPACITY  = 32,
	parameter int SEQ_BITS  = 15,
	parameter int TIME_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// delay[31:0], use_system[32], timer_id[80:33], steady_now[144:81],
	// system_now[208:145], zero pad
	input  logic [215:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result_id[47:0], next_wait[54:48], zero pad
	output logic [55:0]  m_tdata,
	// status[2:0]
	output logic [2:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import otq_pkg::*;
	`include "ordered_timer_queue_top_macros.svh"

	localparam int TW = (TIME_BITS + SEQ_BITS >= 47) ? 47 - SEQ_BITS : TIME_BITS;
	localparam int PAD = 47 - TW - SEQ_BITS;
	localparam int CW = $clog2(CAPACITY);
	localparam logic [CW-1:0] CNT_LAST = CW'(CAPACITY - 1);
	localparam logic [SEQ_BITS:0] TRY_LAST = {1'b0, {SEQ_BITS{1'b1}}};

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_PASS   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_WAITC  = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t state_q;

	logic [63:0] start_steady_q, start_system_q;
	logic [63:0] steady_rel_q, system_rel_q;
	kind_t       op_q;
	logic        sys_q;
	logic [TW-1:0] t_q;
	logic [SEQ_BITS-1:0] seq_q, cseq_q;
	logic [SEQ_BITS:0]   tries_q;
	logic        ins_phase_q, ins_en_q, ins_done_q;
	logic        kill_en_q;
	logic [ID_W-1:0] kill_id_q;
	logic        base_q;
	logic [CW-1:0] cnt_q;
	logic        free_q, match_q, found_q;
	logic [1:0]  minv_q;
	logic [46:0] min_q [2];
	logic [2:0]  res_st_q;
	logic [ID_W-1:0] res_id_q;
	logic        res_last_q;
	logic [WAIT_W-1:0] wait_q;

	entry_t chain [CAPACITY];
	entry_t tap_in, tap_mod;
	logic   tap_kill, tap_ins;
	logic [ID_W-1:0] cand_id;
	logic   shift;

	// Build the candidate ID from the latched expiry and sequence
	generate
		if (PAD > 0) begin : g_pad
			assign cand_id = {sys_q, {PAD{1'b0}}, t_q, cseq_q};
		end else begin : g_nopad
			assign cand_id = {sys_q, t_q, cseq_q};
		end
	endgenerate

	// Ring of cells; the tap feeds the first cell
	assign shift = (state_q == S_PASS);
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				otq_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
					.d(tap_mod), .q(chain[gi]));
			end else begin : g_rest
				otq_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
					.d(chain[gi-1]), .q(chain[gi]));
			end
		end
	endgenerate

	// Drop or insert at the ring tap
	assign tap_in   = chain[CAPACITY-1];
	assign tap_kill = kill_en_q && tap_in.valid && (tap_in.id == kill_id_q);
	assign tap_ins  = ins_en_q && !ins_done_q && !tap_in.valid;
	always_comb begin
		tap_mod.valid = tap_ins || (tap_in.valid && !tap_kill);
		tap_mod.id    = tap_ins ? cand_id : tap_in.id;
	end

	// Expiry test of the current base's earliest entry
	logic [63:0] base_now;
	logic [63:0] base_time;
	logic        expire_now;
	assign base_now   = base_q ? system_rel_q : steady_rel_q;
	assign base_time  = 64'(min_q[base_q][46:SEQ_BITS]);
	assign expire_now = minv_q[base_q] && (base_now > base_time);

	// Wait per base, clipped to the cap
	logic [WAIT_W-1:0] wait_b [2];
	always_comb begin
		logic [63:0] e0, e1, d0, d1;
		e0 = 64'(min_q[0][46:SEQ_BITS]);
		e1 = 64'(min_q[1][46:SEQ_BITS]);
		d0 = e0 - steady_rel_q;
		d1 = e1 - system_rel_q;
		wait_b[0] = WAIT_CAP;
		wait_b[1] = WAIT_CAP;
		if (minv_q[0]) begin
			wait_b[0] = (e0 <= steady_rel_q) ? '0 :
				((d0 > 64'(WAIT_CAP)) ? WAIT_CAP : d0[WAIT_W-1:0]);
		end
		if (minv_q[1]) begin
			wait_b[1] = (e1 <= system_rel_q) ? '0 :
				((d1 > 64'(WAIT_CAP)) ? WAIT_CAP : d1[WAIT_W-1:0]);
		end
	end

	// Hold configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_steady_q <= '0;
			start_system_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == 1'b0) begin
				start_steady_q <= cfg_data;
			end else begin
				start_system_q <= cfg_data;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);

	// Sequence requests through scans and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seq_q       <= '0;
			m_tvalid    <= 1'b0;
			ins_en_q    <= 1'b0;
			ins_done_q  <= 1'b0;
			kill_en_q   <= 1'b0;
			cnt_q       <= '0;
			minv_q      <= '0;
			free_q      <= 1'b0;
			match_q     <= 1'b0;
			found_q     <= 1'b0;
			ins_phase_q <= 1'b0;
			base_q      <= 1'b0;
			tries_q     <= '0;
			res_last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						logic [63:0] srel, yrel;
						srel = s_tdata[144:81] - start_steady_q;
						yrel = s_tdata[208:145] - start_system_q;
						steady_rel_q <= srel;
						system_rel_q <= yrel;
						op_q      <= kind_t'(s_tuser);
						sys_q     <= s_tdata[32];
						t_q       <= (s_tdata[32] ? yrel[TW-1:0] : srel[TW-1:0]) +
							TW'(s_tdata[31:0]);
						cseq_q    <= seq_q + 1'b1;
						tries_q   <= '0;
						ins_phase_q <= 1'b0;
						ins_en_q  <= 1'b0;
						base_q    <= 1'b0;
						kill_en_q <= (kind_t'(s_tuser) == KIND_CANCEL);
						kill_id_q <= s_tdata[80:33];
						cnt_q     <= '0;
						free_q    <= 1'b0;
						match_q   <= 1'b0;
						found_q   <= 1'b0;
						minv_q    <= '0;
						ins_done_q <= 1'b0;
						if (kind_t'(s_tuser) != KIND_NONE) begin
							state_q <= S_PASS;
						end
					end
				end
				S_PASS: begin
					// Gather flags and per-base minimum on the tap
					if (!tap_in.valid) free_q <= 1'b1;
					if (tap_kill) found_q <= 1'b1;
					if (tap_ins) ins_done_q <= 1'b1;
					if (tap_in.valid && tap_in.id == cand_id) match_q <= 1'b1;
					if (tap_mod.valid && (!minv_q[tap_mod.id[47]] ||
						tap_mod.id[46:0] < min_q[tap_mod.id[47]])) begin
						minv_q[tap_mod.id[47]] <= 1'b1;
						min_q[tap_mod.id[47]]  <= tap_mod.id[46:0];
					end
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= S_DECIDE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DECIDE: begin
					case (op_q)
						KIND_CREATE: begin
							if (ins_phase_q) begin
								res_st_q   <= ST_CREATED;
								res_id_q   <= cand_id;
								res_last_q <= 1'b1;
								seq_q      <= cseq_q;
								ins_en_q   <= 1'b0;
								state_q    <= S_WAITC;
							end else if (!free_q || (match_q && tries_q == TRY_LAST)) begin
								res_st_q   <= ST_FULL;
								res_id_q   <= '0;
								res_last_q <= 1'b1;
								state_q    <= S_WAITC;
							end else begin
								if (match_q) begin
									tries_q <= tries_q + 1'b1;
									cseq_q  <= cseq_q + 1'b1;
								end else begin
									ins_phase_q <= 1'b1;
									ins_en_q    <= 1'b1;
								end
								free_q     <= 1'b0;
								match_q    <= 1'b0;
								minv_q     <= '0;
								ins_done_q <= 1'b0;
								state_q    <= S_PASS;
							end
						end
						KIND_CANCEL: begin
							res_st_q   <= found_q ? ST_CANCELLED : ST_NOT_FOUND;
							res_id_q   <= found_q ? kill_id_q : '0;
							res_last_q <= 1'b1;
							state_q    <= S_WAITC;
						end
						default: begin
							if (kill_en_q) begin
								// Report the entry the last scan removed
								res_st_q   <= ST_EXPIRED;
								res_id_q   <= kill_id_q;
								res_last_q <= 1'b0;
								kill_en_q  <= 1'b0;
								state_q    <= S_WAITC;
							end else if (expire_now) begin
								kill_en_q <= 1'b1;
								kill_id_q <= {base_q, min_q[base_q]};
								minv_q    <= '0;
								state_q   <= S_PASS;
							end else if (!base_q) begin
								base_q <= 1'b1;
							end else begin
								res_st_q   <= ST_CHECK_DONE;
								res_id_q   <= '0;
								res_last_q <= 1'b1;
								state_q    <= S_WAITC;
							end
						end
					endcase
				end
				S_WAITC: begin
					wait_q   <= (wait_b[0] < wait_b[1]) ? wait_b[0] : wait_b[1];
					m_tvalid <= 1'b1;
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						state_q  <= res_last_q ? S_IDLE : S_DECIDE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tdata = {1'b0, wait_q, res_id_q};
	assign m_tuser = res_st_q;
	assign m_tlast = res_last_q;

	`OTQ_ASSERT_IMPL(a_one_request, s_tready, !m_tvalid, "request taken while result pending")
	`OTQ_ASSERT_IMPL(a_expired_not_last, m_tvalid && m_tuser == ST_EXPIRED, !m_tlast,
		"expired result marked last")
	`OTQ_ASSERT_IMPL(a_full_zero_id, m_tvalid && m_tuser == ST_FULL, m_tdata[47:0] == '0,
		"table full result carries an ID")
	`OTQ_ASSERT_NEXT(a_scan_count, state_q != S_PASS, cnt_q == '0,
		"scan counter not cleared outside a scan")
endmodule
